@@ hdl/pls_pkg.sv @@
// ----------------------------------------------------------------------------
// pls_pkg: shared types and codes for the positional list store
// Request and response transaction types, operation and status codes, the
// controller state type and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package pls_pkg;

	// Default parameter values.
	localparam int CAPACITY_DEF   = 32;
	localparam int DATA_WIDTH_DEF = 32;

	// Fixed field widths of the transactions.
	localparam int FUNC_W   = 3;
	localparam int POS_W    = 6;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = 6;

	// Operation codes.
	localparam logic [FUNC_W-1:0] OP_INSERT = 3'd0;
	localparam logic [FUNC_W-1:0] OP_DELETE = 3'd1;
	localparam logic [FUNC_W-1:0] OP_UPDATE = 3'd2;
	localparam logic [FUNC_W-1:0] OP_FWD    = 3'd3;
	localparam logic [FUNC_W-1:0] OP_REV    = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic signed [VAL_W-1:0] value_out;
		logic [ENTRY_W-1:0]      entries;
		logic                    last;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WALK
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;  // capture the incoming request
		logic exec;  // apply the request and post its single result
		logic step;  // post one traversal result
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic walk_start; // request is a traversal of a non-empty list
		logic walk_last;  // the traversal cursor is on the final entry
		logic out_free;   // the output register can take a result this cycle
	} ctrl_stat_t;

endpackage

@@ hdl/positional_list_store.sv @@
// ----------------------------------------------------------------------------
// positional_list_store: ordered list of signed values indexed by position
// Requests arrive on the req channel (req_valid, req_stall, req); results
// leave on the rsp channel (rsp_valid, rsp_stall, rsp).
// Insert, delete and update each give one result. Forward and reverse
// traversals give one result per entry, the final one marked by last; a
// traversal of an empty list gives a single empty-status result.
// A request is taken into the request register; a single-result request then
// executes, the cell row shifting in parallel, once the output register is
// free, and a traversal steps through its entries. Each result shows on rsp
// in the cycle after its execution or step. The single output register sets
// the pace: while rsp_stall holds a result there, execution and traversal
// wait, and req_stall stays high until a request has posted its results.
// Reset empties the list and clears the output valid flag; cell contents are
// not cleared, since only cells below the count are ever read.
// ----------------------------------------------------------------------------
module positional_list_store
	import pls_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	// Controller.
	pls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Datapath.
	pls_dp #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ hdl/pls_ctrl.sv @@
// ----------------------------------------------------------------------------
// pls_ctrl: controller of the positional list store
// Sequences each request: capture, execute, then one step per entry for a
// traversal, waiting whenever the output register is still occupied.
// ----------------------------------------------------------------------------
module pls_ctrl
	import pls_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	output ctrl_cmd_t  cmd,
	input  ctrl_stat_t stat
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.walk_start) begin
					state_nxt = S_WALK;
				end else if (stat.out_free) begin
					cmd.exec  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			S_WALK: begin
				if (stat.out_free) begin
					cmd.step = 1'b1;
					if (stat.walk_last) begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/pls_dp.sv @@
// ----------------------------------------------------------------------------
// pls_dp: datapath of the positional list store
// Holds the request register, the shifting cell row, the entry count, the
// traversal cursor and the output register.
// ----------------------------------------------------------------------------
module pls_dp
	import pls_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  req_t       req,
	input  ctrl_cmd_t  cmd,
	output ctrl_stat_t stat,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

	req_t                  req_q;
	logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      walk_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic [CMP_W-1:0]      pos_c;
	logic [CMP_W-1:0]      cnt_c;
	logic [DATA_WIDTH-1:0] wr_val;
	logic                  ins_ok;
	logic                  del_ok;
	logic                  upd_ok;
	logic [CNT_W-1:0]      count_nxt;
	logic [STATUS_W-1:0]   exec_status;
	logic [CNT_W-1:0]      rev_idx;
	logic [IDX_W-1:0]      rd_idx;
	logic [DATA_WIDTH-1:0] rd_val;
	logic signed [VAL_W-1:0] rd_val_out;
	logic                  out_free;
	logic                  is_walk;

	// Request register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// Fit the 32-bit input value to the cell width, and cell values to 32 bits.
	generate
		if (DATA_WIDTH > VAL_W) begin : g_wide
			assign wr_val     = {{(DATA_WIDTH-VAL_W){req_q.value_in[VAL_W-1]}},
				req_q.value_in};
			assign rd_val_out = rd_val[VAL_W-1:0];
		end else if (DATA_WIDTH == VAL_W) begin : g_same
			assign wr_val     = req_q.value_in;
			assign rd_val_out = rd_val;
		end else begin : g_narrow
			assign wr_val     = req_q.value_in[DATA_WIDTH-1:0];
			assign rd_val_out = {{(VAL_W-DATA_WIDTH){rd_val[DATA_WIDTH-1]}}, rd_val};
		end
	endgenerate

	// Decode the request against the current count.
	assign pos_c   = CMP_W'(req_q.position);
	assign cnt_c   = CMP_W'(count_q);
	assign is_walk = (req_q.func == OP_FWD) || (req_q.func == OP_REV);
	assign ins_ok  = (req_q.func == OP_INSERT) && (pos_c <= cnt_c) && (cnt_c < CAP_C);
	assign del_ok  = (req_q.func == OP_DELETE) && (pos_c < cnt_c);
	assign upd_ok  = (req_q.func == OP_UPDATE) && (pos_c < cnt_c);

	always_comb begin
		count_nxt = count_q;
		if (ins_ok) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (del_ok) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		exec_status = ST_INVALID;
		if (ins_ok || del_ok || upd_ok) begin
			exec_status = ST_OK;
		end else if (req_q.func == OP_INSERT && pos_c <= cnt_c) begin
			exec_status = ST_FULL;
		end else if (is_walk) begin
			exec_status = ST_EMPTY;
		end
	end

	// Cell row: each cell shifts from a neighbor or takes the new value.
	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			localparam logic [CMP_W-1:0] I_C = CMP_W'(gi);
			logic [DATA_WIDTH-1:0] up_val;
			logic [DATA_WIDTH-1:0] down_val;
			if (gi == 0) begin : g_first
				assign down_val = cell_q[gi];
			end else begin : g_mid
				assign down_val = cell_q[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_top
				assign up_val = cell_q[gi];
			end else begin : g_low
				assign up_val = cell_q[gi+1];
			end
			always_ff @(posedge clk) begin
				if (cmd.exec) begin
					if ((ins_ok || upd_ok) && I_C == pos_c) begin
						cell_q[gi] <= wr_val;
					end else if (ins_ok && I_C > pos_c) begin
						cell_q[gi] <= down_val;
					end else if (del_ok && I_C >= pos_c) begin
						cell_q[gi] <= up_val;
					end
				end
			end
		end
	endgenerate

	// Count and traversal cursor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			walk_q  <= '0;
		end else begin
			if (cmd.exec) begin
				count_q <= count_nxt;
			end
			if (cmd.step) begin
				walk_q <= stat.walk_last ? '0 : walk_q + IDX_W'(1);
			end
		end
	end

	// Read address of the traversal.
	assign rev_idx = count_q - CNT_W'(1) - CNT_W'(walk_q);
	assign rd_idx  = (req_q.func == OP_FWD) ? walk_q : rev_idx[IDX_W-1:0];
	assign rd_val  = cell_q[rd_idx];

	assign out_free        = !rsp_valid_q || !rsp_stall;
	assign stat.out_free   = out_free;
	assign stat.walk_start = is_walk && (count_q != '0);
	assign stat.walk_last  = (CNT_W'(walk_q) + CNT_W'(1)) == count_q;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.exec || cmd.step) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q.status    <= exec_status;
			rsp_q.value_out <= '0;
			rsp_q.entries   <= ENTRY_W'(count_nxt);
			rsp_q.last      <= 1'b1;
		end else if (cmd.step) begin
			rsp_q.status    <= ST_OK;
			rsp_q.value_out <= rd_val_out;
			rsp_q.entries   <= ENTRY_W'(count_q);
			rsp_q.last      <= stat.walk_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
